// ----- sv/ilid_pkg.sv -----
`timescale 1ns / 1ps

package ilid_pkg;

    localparam int CAPACITY = 64;

    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] OP_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      found;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

// ----- sv/ilid_cmd_if.sv -----
`timescale 1ns / 1ps

interface ilid_cmd_if;

    logic                                        valid;
    logic                                        ready;
    logic [ilid_pkg::FUNC_W-1:0]                 func;
    logic [ilid_pkg::POS_W-1:0]                  position;
    logic signed [ilid_pkg::VALUE_W-1:0]         item_value;

    modport source (output valid, output func, output position, output item_value,
                    input ready);
    modport sink (input valid, input func, input position, input item_value,
                  output ready);

endinterface

// ----- sv/ilid_rsp_if.sv -----
`timescale 1ns / 1ps

interface ilid_rsp_if;

    logic                                        valid;
    logic                                        ready;
    logic signed [ilid_pkg::VALUE_W-1:0]         read_value;
    logic                                        found;
    logic [ilid_pkg::STATUS_W-1:0]               status;
    logic [ilid_pkg::COUNT_W-1:0]                entry_count;

    modport source (output valid, output read_value, output found, output status,
                    output entry_count, input ready);
    modport sink (input valid, input read_value, input found, input status,
                  input entry_count, output ready);

endinterface

// ----- sv/indexed_list_insert_delete_top.sv -----
`timescale 1ns / 1ps

// Indexed list store: an ordered sequence of up to CAPACITY signed 32-bit values.
// Commands arrive on the cmd channel (func, position, item_value) and each produces
// exactly one transaction on the rsp channel (read_value, found, status, entry_count).
// Commands are handled one at a time; cmd.ready is high only while the block is idle.
// A read that hits fetches its value from the memory in a read state before its result
// is ready, and the next command is taken once that result has passed on to the output
// register. An insert at position p into a list of length L moves the L - p entries
// behind the position, and a delete the L - p - 1 behind it, one place per cycle through
// the single read/write port pair of the value memory; an insert then writes its value
// at p. The next command is again taken once the result has passed on. Rejected commands
// and unused codes go straight to their result. The sustained rate is therefore set by
// that shift loop. Reset clears the length to zero; the value memory is not cleared, and
// its contents outside the stored range are never used. The result sits in an output
// register; while the receiver holds rsp.ready low the block finishes the next command
// but keeps it until the register is free, so no transaction is lost or repeated.
module indexed_list_insert_delete_top #(
    parameter int CAPACITY = ilid_pkg::CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    ilid_cmd_if.sink   cmd,
    ilid_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    ilid_pkg::cmd_t               cmd_data;
    ilid_pkg::rsp_t               res;
    logic                         res_valid;
    logic                         res_ready;
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [ilid_pkg::VALUE_W-1:0] ram_wr_data;
    logic [AW-1:0]                ram_rd_addr;
    logic [ilid_pkg::VALUE_W-1:0] ram_rd_data;

    logic                         out_valid_reg, out_valid_next;
    ilid_pkg::rsp_t               out_data_reg,  out_data_next;

    assign cmd_data.func       = cmd.func;
    assign cmd_data.position   = cmd.position;
    assign cmd_data.item_value = cmd.item_value;

    ilid_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .cmd         (cmd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    ilid_ram #(
        .WIDTH (ilid_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_data_reg.read_value;
    assign rsp.found       = out_data_reg.found;
    assign rsp.status      = out_data_reg.status;
    assign rsp.entry_count = out_data_reg.entry_count;

endmodule

// ----- sv/ilid_ram.sv -----
`timescale 1ns / 1ps

module ilid_ram #(
    parameter int WIDTH = ilid_pkg::VALUE_W,
    parameter int DEPTH = ilid_pkg::CAPACITY,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ilid_seq.sv -----
`timescale 1ns / 1ps

module ilid_seq #(
    parameter int CAPACITY = ilid_pkg::CAPACITY,
    localparam int AW      = $clog2(CAPACITY),
    localparam int LW      = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  ilid_pkg::cmd_t               cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ilid_pkg::rsp_t               res,
    output logic                         ram_wr_en,
    output logic [AW-1:0]                ram_wr_addr,
    output logic [ilid_pkg::VALUE_W-1:0] ram_wr_data,
    output logic [AW-1:0]                ram_rd_addr,
    input  logic [ilid_pkg::VALUE_W-1:0] ram_rd_data
);

    localparam int CW = ((LW > ilid_pkg::POS_W) ? LW : ilid_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    state_t                          state_reg,  state_next;
    logic [LW-1:0]                   len_reg,    len_next;
    logic                            del_reg,    del_next;
    logic [AW-1:0]                   addr_reg,   addr_next;
    logic [ilid_pkg::VALUE_W-1:0]    val_reg,    val_next;
    logic [AW-1:0]                   cursor_reg, cursor_next;
    logic [AW-1:0]                   wptr_reg,   wptr_next;
    logic                            pend_reg,   pend_next;
    logic [LW-1:0]                   rem_reg,    rem_next;
    logic [ilid_pkg::VALUE_W-1:0]    rdv_reg,    rdv_next;
    logic                            found_reg,  found_next;
    logic [ilid_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic [CW-1:0] len_ext;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] ins_pos;
    logic          full;

    assign len_ext = CW'(len_reg);
    assign pos_ext = CW'(cmd.position);
    assign full    = (len_reg == LW'(CAPACITY));

    always_comb
    begin
        case (cmd.func)
            ilid_pkg::OP_FRONT:  ins_pos = '0;
            ilid_pkg::OP_APPEND: ins_pos = len_ext;
            default:             ins_pos = pos_ext;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        del_next    = del_reg;
        addr_next   = addr_reg;
        val_next    = val_reg;
        cursor_next = cursor_reg;
        wptr_next   = wptr_reg;
        pend_next   = pend_reg;
        rem_next    = rem_reg;
        rdv_next    = rdv_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wptr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = cursor_reg;

        case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = pos_ext[AW-1:0];
                if (cmd_valid)
                begin
                    rdv_next    = '0;
                    found_next  = 1'b0;
                    status_next = ilid_pkg::ST_DONE;
                    val_next    = cmd.item_value;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                    case (cmd.func)
                        ilid_pkg::OP_READ:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                rdv_next    = ilid_pkg::MISS_VALUE;
                                status_next = ilid_pkg::ST_RANGE;
                            end
                        end
                        ilid_pkg::OP_FRONT, ilid_pkg::OP_APPEND, ilid_pkg::OP_INSERT:
                        begin
                            if (ins_pos > len_ext)
                            begin
                                status_next = ilid_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ilid_pkg::ST_FULL;
                            end
                            else
                            begin
                                del_next    = 1'b0;
                                addr_next   = ins_pos[AW-1:0];
                                rem_next    = LW'(len_ext - ins_pos);
                                cursor_next = AW'(len_ext - CW'(1));
                                state_next  = S_SHIFT;
                            end
                        end
                        ilid_pkg::OP_DELETE:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                del_next    = 1'b1;
                                rem_next    = LW'(len_ext - pos_ext - CW'(1));
                                cursor_next = AW'(pos_ext + CW'(1));
                                state_next  = S_SHIFT;
                            end
                            else
                            begin
                                status_next = ilid_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rdv_next   = ram_rd_data;
                found_next = 1'b1;
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                ram_wr_en = pend_reg;
                if (rem_reg != '0)
                begin
                    pend_next = 1'b1;
                    rem_next  = rem_reg - LW'(1);
                    if (del_reg)
                    begin
                        wptr_next   = cursor_reg - AW'(1);
                        cursor_next = cursor_reg + AW'(1);
                    end
                    else
                    begin
                        wptr_next   = cursor_reg + AW'(1);
                        cursor_next = cursor_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (del_reg)
                    begin
                        len_next   = len_reg - LW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = addr_reg;
                ram_wr_data = val_reg;
                len_next    = len_reg + LW'(1);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
            rem_reg    <= '0;
            del_reg    <= 1'b0;
            addr_reg   <= '0;
            val_reg    <= '0;
            cursor_reg <= '0;
            wptr_reg   <= '0;
            rdv_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= ilid_pkg::ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
            rem_reg    <= rem_next;
            del_reg    <= del_next;
            addr_reg   <= addr_next;
            val_reg    <= val_next;
            cursor_reg <= cursor_next;
            wptr_reg   <= wptr_next;
            rdv_reg    <= rdv_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign cmd_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.read_value  = rdv_reg;
    assign res.found       = found_reg;
    assign res.status      = status_reg;
    assign res.entry_count = ilid_pkg::COUNT_W'(len_reg);

endmodule
